// ===== hdl/ltfb_pkg.sv =====
// Laws 3x3 texture filter bank: shared types, constants and arithmetic helpers.
// Used by ltfb_filter and laws_texture_filter_bank_3x3_core; no dependencies.
package ltfb_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_WID_W  = 11;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RST     = 1024;
    localparam int HEIGHT_RST    = 1024;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // x/3 == (x*1366)>>12 and x/9 == (x*911)>>13 for x <= 1024
    localparam int RECIP_3 = 1366;
    localparam int SHIFT_3 = 12;
    localparam int RECIP_9 = 911;
    localparam int SHIFT_9 = 13;

    typedef logic [PIX_W-1:0]           t_pix;
    typedef logic [2:0][PIX_W-1:0]      t_col3;   // [0] two above, [1] one above, [2] current
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;    // [y][x], y=0 top, x=0 left
    typedef logic [8:0][PIX_W-1:0]      t_resp;   // [v*3+h]
    typedef logic signed [13:0]         t_sum;

    typedef enum logic [1:0] {K_L, K_E, K_S} t_kern;
    typedef enum logic [1:0] {DIV_36, DIV_12, DIV_4} t_div;

    localparam t_kern KERN_ORDER [3] = '{K_L, K_E, K_S};
    localparam t_div  DIV_KIND [9] = '{DIV_36, DIV_12, DIV_12,
                                       DIV_12, DIV_4,  DIV_4,
                                       DIV_12, DIV_4,  DIV_4};

    // position flags of one pixel, carried along with it
    typedef struct packed {
        logic first_row;
        logic row_one;
        logic last_row;
        logic last_col;
        logic col_ge1;
        logic col_ge2;
    } t_pos_flags;

    // one 3-tap kernel applied to (a, b, c)
    function automatic t_sum kern3(input t_sum a, input t_sum b, input t_sum c,
                                   input t_kern k);
        t_sum r;
        case (k)
            K_L:     r = a + (b <<< 1) + c;
            K_E:     r = c - a;
            K_S:     r = (b <<< 1) - a - c;
            default: r = '0;
        endcase
        return r;
    endfunction

    // rounded divide, truncation toward zero, absolute value, saturate at 255
    function automatic t_pix resp_scale(input t_sum s, input t_div kind);
        logic signed [14:0] t;
        logic [13:0]        mag;
        logic [11:0]        qtr;
        logic [21:0]        prod;
        logic [11:0]        q;
        logic [14:0]        half;
        case (kind)
            DIV_36:  half = 15'd18;
            DIV_12:  half = 15'd6;
            default: half = 15'd2;
        endcase
        t    = 15'(s) + half;
        mag  = t[14] ? 14'(-t) : 14'(t);
        qtr  = 12'(mag >> 2);
        prod = '0;
        case (kind)
            DIV_36: begin
                prod = 22'(qtr) * 22'(RECIP_9);
                q    = 12'(prod >> SHIFT_9);
            end
            DIV_12: begin
                prod = 22'(qtr) * 22'(RECIP_3);
                q    = 12'(prod >> SHIFT_3);
            end
            default: q = qtr;
        endcase
        return (q > 12'd255) ? 8'hff : q[7:0];
    endfunction

endpackage

// ===== hdl/laws_texture_filter_bank_3x3_core.sv =====
// Path: an accepted pixel passes stage 1, the stage-2 context and the output register.
// Throughput: one pixel per cycle without output stall; a pixel causing more than
// one result (row ends and the last row) holds the input until its last result is
// issued; the single filter unit feeds the output register one result per cycle.
// Reset: synchronous; counters zero, height 1024, width 1024 capped at MAX_WIDTH.
// The two line memories are not cleared; their stale data never reaches a result.
module laws_texture_filter_bank_3x3_core #(
    parameter int MAX_WIDTH = ltfb_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ltfb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ltfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ltfb_pkg::t_pix                    i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ltfb_pkg::t_pix                    o_resp_l_l,
    output ltfb_pkg::t_pix                    o_resp_e_l,
    output ltfb_pkg::t_pix                    o_resp_s_l,
    output ltfb_pkg::t_pix                    o_resp_l_e,
    output ltfb_pkg::t_pix                    o_resp_e_e,
    output ltfb_pkg::t_pix                    o_resp_s_e,
    output ltfb_pkg::t_pix                    o_resp_l_s,
    output ltfb_pkg::t_pix                    o_resp_e_s,
    output ltfb_pkg::t_pix                    o_resp_s_s,
    output logic [ltfb_pkg::ROW_W-1:0]        o_out_row,
    output logic [ltfb_pkg::OUT_COL_W-1:0]    o_out_col,
    output logic                              o_last_of_item
);
    import ltfb_pkg::*;

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RST_WD = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    // ---------------- configuration and position counters ----------------
    logic [CW-1:0]      r_last_col;
    logic [ROW_W-1:0]   r_last_row;
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;

    logic [CFG_WID_W-1:0] cfg_wd;
    logic [ROW_W-1:0]     cfg_ht;
    logic [CW-1:0]        cfg_last_col;
    logic [ROW_W-1:0]     cfg_last_row;
    logic                 cfg_hit;

    logic accept;
    logic s1_adv;

    always_comb begin
        cfg_wd = i_cfg_data[CFG_WID_W-1:0];
        cfg_ht = i_cfg_data[ROW_W-1:0];
        if (cfg_wd == '0) begin
            cfg_last_col = '0;
        end else if (32'(cfg_wd) > 32'(MAX_WIDTH)) begin
            cfg_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = CW'(cfg_wd - 11'd1);
        end
        cfg_last_row = (cfg_ht == '0) ? '0 : cfg_ht - 16'd1;
        cfg_hit = i_cfg_we &&
                  (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_WD - 1);
            r_last_row <= ROW_W'(HEIGHT_RST - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_last_col <= cfg_last_col;
                REG_IMAGE_HEIGHT: r_last_row <= cfg_last_row;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    t_pos_flags pos_flg;
    always_comb begin
        pos_flg.first_row = (r_row == '0);
        pos_flg.row_one   = (r_row == 16'd1);
        pos_flg.last_row  = (r_row == r_last_row);
        pos_flg.last_col  = (r_col == r_last_col);
        pos_flg.col_ge1   = (r_col != '0);
        pos_flg.col_ge2   = (r_col > CW'(1));
    end

    // ---------------- stage 1: line memory read ----------------
    t_pix mem_two [MAX_WIDTH];
    t_pix mem_one [MAX_WIDTH];

    logic               r_s1_valid;
    t_pix               r_s1_pix;
    logic [ROW_W-1:0]   r_s1_row;
    logic [CW-1:0]      r_s1_col;
    t_pos_flags         r_s1_flg;
    t_pix               r_rd_two;
    t_pix               r_rd_one;
    logic               r_byp;
    t_pix               r_byp_two;
    t_pix               r_byp_one;

    t_col3              s1_cur;
    logic [3:0]         s1_pend;
    logic               n_byp;

    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    // a one-pixel-wide image reads the address being written in the same cycle
    assign n_byp      = s1_adv && (r_col == r_s1_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pixel;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_flg  <= pos_flg;
            r_rd_two  <= mem_two[r_col];
            r_rd_one  <= mem_one[r_col];
            r_byp     <= n_byp;
            r_byp_two <= s1_cur[1];
            r_byp_one <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_two[r_s1_col] <= s1_cur[1];
            mem_one[r_s1_col] <= r_s1_pix;
        end
    end

    always_comb begin
        s1_cur[0] = r_byp ? r_byp_two : r_rd_two;
        s1_cur[1] = r_byp ? r_byp_one : r_rd_one;
        s1_cur[2] = r_s1_pix;
        // bit order: above/colA, above/colB, current/colA, current/colB
        s1_pend[0] = !r_s1_flg.first_row && r_s1_flg.col_ge1;
        s1_pend[1] = !r_s1_flg.first_row && r_s1_flg.last_col;
        s1_pend[2] = r_s1_flg.last_row && r_s1_flg.col_ge1;
        s1_pend[3] = r_s1_flg.last_row && r_s1_flg.last_col;
    end

    // window columns of the two previous pixels
    t_col3 r_win_p1;
    t_col3 r_win_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_p1 <= '0;
            r_win_p2 <= '0;
        end else if (s1_adv) begin
            r_win_p2 <= r_win_p1;
            r_win_p1 <= s1_cur;
        end
    end

    // ---------------- stage 2: result issue ----------------
    t_col3              r_ctx_p2;
    t_col3              r_ctx_p1;
    t_col3              r_ctx_cur;
    t_pos_flags         r_ctx_flg;
    logic [ROW_W-1:0]   r_ctx_row;
    logic [CW-1:0]      r_ctx_col;
    logic [3:0]         r_pend;

    logic [1:0]         pick;
    logic [3:0]         pick_oh;
    logic               out_free;
    logic               emit;
    logic [3:0]         n_pend;
    logic               s2_take;

    always_comb begin
        priority if (r_pend[0]) begin
            pick = 2'd0;
        end else if (r_pend[1]) begin
            pick = 2'd1;
        end else if (r_pend[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
        pick_oh  = 4'b0001 << pick;
        out_free = !o_out_valid || !i_out_stall;
        emit     = out_free && (r_pend != '0);
        n_pend   = emit ? (r_pend & ~pick_oh) : r_pend;
        s2_take  = (n_pend == '0);
        s1_adv   = r_s1_valid && s2_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= s1_adv ? s1_pend : n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_ctx_p2  <= r_win_p2;
            r_ctx_p1  <= r_win_p1;
            r_ctx_cur <= s1_cur;
            r_ctx_flg <= r_s1_flg;
            r_ctx_row <= r_s1_row;
            r_ctx_col <= r_s1_col;
        end
    end

    // top/middle/bottom rows out of one raw column
    function automatic t_col3 pick_rows(input t_col3 c, input logic pass_cur,
                                        input logic first_row, input logic row_one);
        t_col3 r;
        r[0] = pass_cur ? (first_row ? c[2] : c[1]) : (row_one ? c[1] : c[0]);
        r[1] = pass_cur ? c[2] : c[1];
        r[2] = c[2];
        return r;
    endfunction

    logic   pass_cur;
    logic   col_b;
    t_col3  raw_l, raw_m, raw_r;
    t_col3  rows_l, rows_m, rows_r;
    t_win   win;
    t_resp  resp;

    always_comb begin
        pass_cur = pick[1];
        col_b    = pick[0];
        if (col_b) begin
            raw_l = r_ctx_flg.col_ge1 ? r_ctx_p1 : r_ctx_cur;
            raw_m = r_ctx_cur;
            raw_r = r_ctx_cur;
        end else begin
            raw_l = r_ctx_flg.col_ge2 ? r_ctx_p2 : r_ctx_p1;
            raw_m = r_ctx_p1;
            raw_r = r_ctx_cur;
        end
        rows_l = pick_rows(raw_l, pass_cur, r_ctx_flg.first_row, r_ctx_flg.row_one);
        rows_m = pick_rows(raw_m, pass_cur, r_ctx_flg.first_row, r_ctx_flg.row_one);
        rows_r = pick_rows(raw_r, pass_cur, r_ctx_flg.first_row, r_ctx_flg.row_one);
        for (int y = 0; y < 3; y++) begin
            win[y][0] = rows_l[y];
            win[y][1] = rows_m[y];
            win[y][2] = rows_r[y];
        end
    end

    ltfb_filter u_filter (
        .i_win  (win),
        .o_resp (resp)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_free) begin
            o_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_resp_l_l     <= resp[0];
            o_resp_e_l     <= resp[1];
            o_resp_s_l     <= resp[2];
            o_resp_l_e     <= resp[3];
            o_resp_e_e     <= resp[4];
            o_resp_s_e     <= resp[5];
            o_resp_l_s     <= resp[6];
            o_resp_e_s     <= resp[7];
            o_resp_s_s     <= resp[8];
            o_out_row      <= pass_cur ? r_ctx_row : r_ctx_row - 16'd1;
            o_out_col      <= OUT_COL_W'(col_b ? r_ctx_col : r_ctx_col - CW'(1));
            o_last_of_item <= (n_pend == '0);
        end
    end

    // ---------------- assertions ----------------
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != '0 && out_free) |=> o_out_valid)
        else $error("pending result not issued to output register");

    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with stage 1 empty");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_item) |=> o_out_valid)
        else $error("result burst broken before last result");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("column counter past row end");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last_row)
        else $error("row counter past frame end");

endmodule

// ===== hdl/ltfb_filter.sv =====
// Nine Laws 3x3 masks on one window, combinational: separable column and row
// kernels, then rounding divide and saturation. Depends on ltfb_pkg.
module ltfb_filter (
    input  ltfb_pkg::t_win  i_win,
    output ltfb_pkg::t_resp o_resp
);
    import ltfb_pkg::*;

    t_sum vsum [3][3];   // [vertical kernel][column]
    t_sum hsum [9];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int x = 0; x < 3; x++) begin
                vsum[v][x] = kern3(t_sum'({6'b0, i_win[0][x]}),
                                   t_sum'({6'b0, i_win[1][x]}),
                                   t_sum'({6'b0, i_win[2][x]}),
                                   KERN_ORDER[v]);
            end
        end
        for (int v = 0; v < 3; v++) begin
            for (int h = 0; h < 3; h++) begin
                hsum[v*3+h] = kern3(vsum[v][0], vsum[v][1], vsum[v][2], KERN_ORDER[h]);
            end
        end
        for (int i = 0; i < 9; i++) begin
            o_resp[i] = resp_scale(hsum[i], DIV_KIND[i]);
        end
    end

endmodule
